>>> sv/escape_sequence_decoder_top_macros.svh
// Assertion macros shared by the escape decoder RTL.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/esd_pkg.sv
// Types and constants for the backslash escape decoder.
package esd_pkg;

   typedef enum logic [3:0] {
      MODE_NORMAL = 4'd0,
      MODE_ESC    = 4'd1,
      MODE_X1     = 4'd2,
      MODE_X2     = 4'd3,
      MODE_U1     = 4'd4,
      MODE_U2     = 4'd5,
      MODE_U3     = 4'd6,
      MODE_U4     = 4'd7,
      MODE_ERR    = 4'd8
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_NUL = 2'd1,
      ST_HEX = 2'd2,
      ST_UNI = 2'd3
   } status_type;

   // One decoded group: up to three byte records, or a single done record.
   typedef struct packed {
      logic [1:0]      nrec;
      logic [2:0][7:0] bytes;
      logic            is_done;
      logic            done_valid;
      status_type      status;
   } group_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_R         = 8'h72;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] CHAR_U         = 8'h75;
   localparam logic [7:0] BYTE_LF        = 8'h0A;
   localparam logic [7:0] BYTE_CR        = 8'h0D;
   localparam logic [7:0] BYTE_TAB       = 8'h09;

   localparam logic [15:0] CP_MAX_1BYTE  = 16'h007F;
   localparam logic [15:0] CP_MAX_2BYTE  = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD2    = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3    = 8'hE0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;

endpackage

>>> sv/esd_parser.sv
// Escape parser: mode state and per-byte decode into one output group.
module esd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          text_byte,
   input  logic                end_of_text,
   output esd_pkg::group_type  grp,
   output logic                grp_push
);
   import esd_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   status_type  err_ff, err_in;

   logic        hex_ok;
   logic [3:0]  hex_d;
   logic [15:0] acc_shift;

   always_comb begin
      hex_ok = 1'b1;
      hex_d  = 4'd0;
      if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
         hex_d = text_byte[3:0];
      end else if ((text_byte >= 8'h61 && text_byte <= 8'h66) ||
                   (text_byte >= 8'h41 && text_byte <= 8'h46)) begin
         hex_d = text_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign acc_shift = {acc_ff[11:0], hex_d};

   // next state
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      err_in  = err_ff;
      if (accept) begin
         if (end_of_text) begin
            mode_in = MODE_NORMAL;
            acc_in  = '0;
            err_in  = ST_OK;
         end else begin
            unique case (mode_ff) inside
               MODE_ERR: begin
               end
               MODE_ESC: begin
                  mode_in = MODE_NORMAL;
                  if (text_byte == CHAR_ZERO) begin
                     mode_in = MODE_ERR;
                     err_in  = ST_NUL;
                     acc_in  = '0;
                  end else if (text_byte == CHAR_X) begin
                     mode_in = MODE_X1;
                     acc_in  = '0;
                  end else if (text_byte == CHAR_U) begin
                     mode_in = MODE_U1;
                     acc_in  = '0;
                  end
               end
               MODE_X1, MODE_X2: begin
                  if (!hex_ok) begin
                     mode_in = MODE_ERR;
                     err_in  = ST_HEX;
                     acc_in  = '0;
                  end else if (mode_ff == MODE_X1) begin
                     mode_in = MODE_X2;
                     acc_in  = acc_shift;
                  end else begin
                     mode_in = MODE_NORMAL;
                     acc_in  = '0;
                  end
               end
               MODE_U1, MODE_U2, MODE_U3: begin
                  if (!hex_ok) begin
                     mode_in = MODE_ERR;
                     err_in  = ST_UNI;
                     acc_in  = '0;
                  end else begin
                     mode_in = mode_type'(mode_ff + 4'd1);
                     acc_in  = acc_shift;
                  end
               end
               MODE_U4: begin
                  mode_in = hex_ok ? MODE_NORMAL : MODE_ERR;
                  acc_in  = '0;
                  if (!hex_ok) begin
                     err_in = ST_UNI;
                  end
               end
               default: begin
                  mode_in = (text_byte == CHAR_BACKSLASH) ? MODE_ESC : MODE_NORMAL;
               end
            endcase
         end
      end
   end

   // outputs
   always_comb begin
      grp            = '0;
      grp.nrec       = 2'd1;
      grp.status     = ST_OK;
      grp_push       = 1'b0;
      if (accept) begin
         if (end_of_text) begin
            grp_push       = 1'b1;
            grp.is_done    = 1'b1;
            grp.done_valid = (mode_ff == MODE_ESC);
            grp.bytes[0]   = (mode_ff == MODE_ESC) ? CHAR_BACKSLASH : 8'h00;
            if (mode_ff == MODE_X1 || mode_ff == MODE_X2) begin
               grp.status = ST_HEX;
            end else if (mode_ff == MODE_U1 || mode_ff == MODE_U2 ||
                         mode_ff == MODE_U3 || mode_ff == MODE_U4) begin
               grp.status = ST_UNI;
            end else begin
               grp.status = err_ff;
            end
         end else begin
            unique case (mode_ff) inside
               MODE_ERR, MODE_X1, MODE_U1, MODE_U2, MODE_U3: begin
               end
               MODE_ESC: begin
                  grp_push = !(text_byte == CHAR_ZERO || text_byte == CHAR_X ||
                               text_byte == CHAR_U);
                  if (text_byte == CHAR_N) begin
                     grp.bytes[0] = BYTE_LF;
                  end else if (text_byte == CHAR_R) begin
                     grp.bytes[0] = BYTE_CR;
                  end else if (text_byte == CHAR_T) begin
                     grp.bytes[0] = BYTE_TAB;
                  end else begin
                     grp.bytes[0] = text_byte;
                  end
               end
               MODE_X2: begin
                  grp_push     = hex_ok;
                  grp.bytes[0] = acc_shift[7:0];
               end
               MODE_U4: begin
                  grp_push = hex_ok;
                  if (acc_shift <= CP_MAX_1BYTE) begin
                     grp.bytes[0] = acc_shift[7:0];
                  end else if (acc_shift <= CP_MAX_2BYTE) begin
                     grp.nrec     = 2'd2;
                     grp.bytes[0] = UTF8_LEAD2 | {3'b000, acc_shift[10:6]};
                     grp.bytes[1] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                  end else begin
                     grp.nrec     = 2'd3;
                     grp.bytes[0] = UTF8_LEAD3 | {4'b0000, acc_shift[15:12]};
                     grp.bytes[1] = UTF8_CONT | {2'b00, acc_shift[11:6]};
                     grp.bytes[2] = UTF8_CONT | {2'b00, acc_shift[5:0]};
                  end
               end
               default: begin
                  grp_push     = (text_byte != CHAR_BACKSLASH);
                  grp.bytes[0] = text_byte;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_NORMAL;
         acc_ff  <= '0;
         err_ff  <= ST_OK;
      end else begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
         err_ff  <= err_in;
      end
   end

endmodule

>>> sv/escape_sequence_decoder_top.sv
// Usage: backslash escape decoder, one text byte in per transfer, decoded records out.
// req channel: req_tdata is the text byte, req_tlast marks the end item (no byte).
// rsp channel: one transfer per result record; rsp_tlast marks the last record
//   caused by an input item, rsp_tuser carries byte_valid, done_res and status.
// Each item is decoded in the cycle it is accepted; a group it yields lands in a
// two-entry group queue; the queue head is sent record by record.
// An item's group is registered into the queue; its first record goes out once the group heads the queue.
// Throughput: one item per cycle while items yield at most one record and rsp_tready
//   is high; a \uHHHH item yielding two or three UTF-8 bytes holds the output until
//   each byte is sent, and input takes stall once both queue entries are in use.
// Items that yield nothing (backslash, leading hex digits, bytes after an error)
//   produce no transfer.
// The end item gives exactly one done record whose status is the text's status;
//   a nonzero status means the consumer drops the text.
// Reset clears the parse state and empties the queue; no clearing pass is needed.
// When the receiver stalls, the head record holds and req_tready drops once the
//   queue is full; req_tready never depends on rsp_tready in the same cycle.
module escape_sequence_decoder_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] text_byte
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [3:0] rsp_tuser,   // [0] byte_valid, [1] done_res, [3:2] status
   output logic       rsp_tlast    // last_of_run
);
   import esd_pkg::*;
   `include "escape_sequence_decoder_top_macros.svh"

   group_type          q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [1:0]         rec_idx_ff, rec_idx_in;

   group_type grp;
   group_type head;
   logic      grp_push;
   logic      accept;
   logic      rsp_xfer;
   logic      rec_last;
   logic      pop;

   assign req_tready = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   esd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_byte   (req_tdata),
      .end_of_text (req_tlast),
      .grp         (grp),
      .grp_push    (grp_push)
   );

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;
   assign rec_last   = (rec_idx_ff == (head.nrec - 2'd1));
   assign pop        = rsp_xfer && rec_last;

   assign rsp_tdata = head.bytes[rec_idx_ff];
   assign rsp_tuser = {head.status, head.is_done, head.is_done ? head.done_valid : 1'b1};
   assign rsp_tlast = rec_last;

   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      cnt_in     = cnt_ff;
      rec_idx_in = rec_idx_ff;
      if (grp_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (grp_push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !grp_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
      if (rsp_xfer) begin
         rec_idx_in = rec_last ? 2'd0 : rec_idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         cnt_ff     <= '0;
         rec_idx_ff <= '0;
      end else begin
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         cnt_ff     <= cnt_in;
         rec_idx_ff <= rec_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (grp_push) begin
         q_ff[wr_ptr_ff] <= grp;
      end
   end

   `ESD_ASSERT_NOW(a_push_not_full, grp_push, cnt_ff != QCNT_W'(QUEUE_DEPTH), "push into full queue")
   `ESD_ASSERT_NOW(a_rec_in_group, rsp_tvalid, rec_idx_ff < head.nrec, "record index past group")
   `ESD_ASSERT_NOW(a_done_single, rsp_tvalid && head.is_done, rsp_tlast && rec_idx_ff == 2'd0,
      "done record not a single-record group")
   `ESD_ASSERT_NEXT(a_cnt_grows, grp_push && !pop, cnt_ff == $past(cnt_ff) + 1'b1,
      "queue count did not grow on push")

endmodule
